// ===== src/rsd_pkg.sv =====
`timescale 1ns / 1ps

package rsd_pkg;

    localparam logic [15:0] FRAME_PIXELS_RESET = 16'd64000;
    localparam logic [7:0]  OPC_LONG           = 8'h80;
    localparam logic [15:0] WORD_END           = 16'h0000;

    typedef enum logic [2:0] {
        PH_OPCODE    = 3'd0,
        PH_DUMP      = 3'd1,
        PH_RUN_COUNT = 3'd2,
        PH_RUN_PIXEL = 3'd3,
        PH_WORD_LO   = 3'd4,
        PH_WORD_HI   = 3'd5
    } rsd_phase_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       frame_start;
    } rsd_in_t;

    typedef struct packed {
        logic [15:0] dest_addr;
        logic [13:0] span_length;
        logic [7:0]  pixel_value;
        logic        end_of_frame;
        logic        overrun;
    } rsd_out_t;

endpackage

// ===== src/run_skip_dump_frame_decoder_core.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                        | Carries
// ----------+------------------------------+---------------------------------------
// input     | s_valid, s_ready, s_data     | one compressed stream byte + frame mark
// result    | m_valid, m_ready, m_data     | one span write or end-of-frame item
// config    | cfg_wr_en, cfg_wr_data       | frame_pixels clip limit
//
// Each item passes through the input register and then the result register; one item
// is taken every cycle while the result side is not stalled.
// Between the two registers sits a single decode pass: one 17-bit add and two
// compares against the clip limit per item, plus a subtract for the clipped length.
// Reset (aresetn low, synchronous) empties both registers and returns the decoder
// to opcode phase at pixel 0 with frame_pixels = 64000.
// A stalled result holds the result register; the input register then holds too.

module run_skip_dump_frame_decoder_core
    import rsd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rsd_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsd_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // configuration
    logic [15:0] frame_pixels_reg;

    // input register
    logic        in_valid_reg;
    rsd_in_t     in_data_reg;

    // result register
    logic        out_valid_reg;
    rsd_out_t    out_data_reg;

    // decoder state
    rsd_phase_t  phase_reg, phase_next;
    logic [13:0] rem_reg, rem_next;
    logic [15:0] dest_reg, dest_next;
    logic [7:0]  wlo_reg, wlo_next;
    logic        ovf_reg, ovf_next;
    logic        done_reg, done_next;

    // state as seen by this byte (after an optional frame restart)
    rsd_phase_t  cur_phase;
    logic [13:0] cur_rem;
    logic [15:0] cur_dest;
    logic [7:0]  cur_wlo;
    logic        cur_ovf;
    logic        cur_done;

    logic        proc;
    logic [7:0]  b;
    logic [15:0] word;

    // decode results
    logic        span_go;     // span or skip moves the destination
    logic        is_emit;     // span produces a result when inside the frame
    logic [15:0] span_len;
    logic        eof_hit;

    // clip datapath
    logic [16:0] span_sum;
    logic        span_over;
    logic        start_out;
    logic [15:0] clip_len;

    logic        res_valid;
    rsd_out_t    res_data;

    // Advance when the result register is free or being emptied this cycle.
    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign b    = in_data_reg.code_byte;
    assign word = {b, cur_wlo};

    // A frame mark clears everything before the byte is decoded as an opcode.
    always_comb begin
        if (in_data_reg.frame_start) begin
            cur_phase = PH_OPCODE;
            cur_rem   = '0;
            cur_dest  = '0;
            cur_wlo   = '0;
            cur_ovf   = 1'b0;
            cur_done  = 1'b0;
        end else begin
            cur_phase = phase_reg;
            cur_rem   = rem_reg;
            cur_dest  = dest_reg;
            cur_wlo   = wlo_reg;
            cur_ovf   = ovf_reg;
            cur_done  = done_reg;
        end
    end

    // Next phase.
    always_comb begin
        phase_next = cur_phase;
        if (!cur_done) begin
            case (cur_phase)
                PH_OPCODE: begin
                    if (b == 8'h00) begin
                        phase_next = PH_RUN_COUNT;
                    end else if (!b[7]) begin
                        phase_next = PH_DUMP;
                    end else if (b == OPC_LONG) begin
                        phase_next = PH_WORD_LO;
                    end
                end
                PH_DUMP: begin
                    if (cur_rem <= 14'd1) begin
                        phase_next = PH_OPCODE;
                    end
                end
                PH_RUN_COUNT: phase_next = PH_RUN_PIXEL;
                PH_RUN_PIXEL: phase_next = PH_OPCODE;
                PH_WORD_LO:   phase_next = PH_WORD_HI;
                PH_WORD_HI: begin
                    phase_next = PH_OPCODE;
                    if (word[15] && word[14]) begin
                        phase_next = PH_RUN_PIXEL;
                    end else if (word[15] && (word[13:0] != 14'd0)) begin
                        phase_next = PH_DUMP;
                    end
                end
                default: phase_next = PH_OPCODE;
            endcase
        end
    end

    // Per-phase decode of counts, spans and the end marker.
    always_comb begin
        rem_next  = cur_rem;
        wlo_next  = cur_wlo;
        done_next = cur_done;
        span_go   = 1'b0;
        is_emit   = 1'b0;
        span_len  = '0;
        eof_hit   = 1'b0;
        if (!cur_done) begin
            case (cur_phase)
                PH_OPCODE: begin
                    if (b != 8'h00 && !b[7]) begin
                        rem_next = {7'd0, b[6:0]};
                    end else if (b[7] && (b[6:0] != 7'd0)) begin
                        span_go  = 1'b1;
                        span_len = {9'd0, b[6:0]};
                    end
                end
                PH_DUMP: begin
                    if (cur_rem != 14'd0) begin
                        rem_next = cur_rem - 14'd1;
                    end
                    span_go  = 1'b1;
                    is_emit  = 1'b1;
                    span_len = 16'd1;
                end
                PH_RUN_COUNT: rem_next = {6'd0, b};
                PH_RUN_PIXEL: begin
                    rem_next = '0;
                    span_go  = (cur_rem != 14'd0);
                    is_emit  = 1'b1;
                    span_len = {2'd0, cur_rem};
                end
                PH_WORD_LO: wlo_next = b;
                PH_WORD_HI: begin
                    if (word == WORD_END) begin
                        done_next = 1'b1;
                        eof_hit   = 1'b1;
                    end else if (!word[15]) begin
                        span_go  = 1'b1;           // long skip
                        span_len = word;
                    end else if (word[14] || (word[13:0] != 14'd0)) begin
                        rem_next = word[13:0];     // long run or long dump
                    end
                end
                default: ;
            endcase
        end
    end

    // Clip against the frame: one add, two compares and a subtract for the clipped length.
    assign span_sum  = {1'b0, cur_dest} + {1'b0, span_len};
    assign span_over = span_sum > {1'b0, frame_pixels_reg};
    assign start_out = cur_dest >= frame_pixels_reg;
    assign clip_len  = span_over ? (frame_pixels_reg - cur_dest) : span_len;

    always_comb begin
        dest_next = cur_dest;
        ovf_next  = cur_ovf;
        if (span_go) begin
            dest_next = span_over ? frame_pixels_reg : span_sum[15:0];
            ovf_next  = cur_ovf | span_over;
        end
    end

    always_comb begin
        res_valid = 1'b0;
        res_data  = '0;
        if (eof_hit) begin
            res_valid             = 1'b1;
            res_data.end_of_frame = 1'b1;
            res_data.overrun      = cur_ovf;
        end else if (is_emit && span_go && !start_out) begin
            res_valid            = 1'b1;
            res_data.dest_addr   = cur_dest;
            res_data.span_length = clip_len[13:0];
            res_data.pixel_value = b;
            res_data.overrun     = ovf_next;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_OPCODE;
            rem_reg          <= '0;
            dest_reg         <= '0;
            wlo_reg          <= '0;
            ovf_reg          <= 1'b0;
            done_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frame_pixels_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc) begin
                out_valid_reg <= res_valid;
                phase_reg     <= phase_next;
                rem_reg       <= rem_next;
                dest_reg      <= dest_next;
                wlo_reg       <= wlo_next;
                ovf_reg       <= ovf_next;
                done_reg      <= done_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (proc && res_valid) begin
            out_data_reg <= res_data;
        end
    end

endmodule

// ===== src/rsd_checker.sv =====
`timescale 1ns / 1ps

module rsd_checker
    import rsd_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input rsd_out_t m_data
);

    logic [16:0] span_end;

    assign span_end = {1'b0, m_data.dest_addr} + {3'd0, m_data.span_length};

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // End marker carries no span.
    a_eof_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.end_of_frame) |->
            (m_data.dest_addr == 16'd0 && m_data.span_length == 14'd0 &&
             m_data.pixel_value == 8'd0))
        else $error("end-of-frame item carries span data");

    // Spans are never empty and never run past the pixel address space.
    a_span_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.end_of_frame) |->
            (m_data.span_length != 14'd0 && !span_end[16]))
        else $error("empty or wrapping span");

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind run_skip_dump_frame_decoder_core rsd_checker u_rsd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== test/run_skip_dump_frame_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module run_skip_dump_frame_decoder_core_tb;
    import rsd_pkg::*;

    // Opcode byte of a short run; the long forms share OPC_LONG and a tag word.
    localparam logic [7:0]  OPC_RUN       = 8'h00;
    localparam logic [15:0] LONG_DUMP_TAG = 16'h8000;
    localparam logic [15:0] LONG_RUN_TAG  = 16'hC000;
    localparam rsd_out_t    NO_SPAN       = '0;

    // Receiver stall patterns.
    localparam int unsigned RX_OPEN  = 0;
    localparam int unsigned RX_COIN  = 1;
    localparam int unsigned RX_CHOKE = 2;

    // Hang limit, set with a wide margin over the slowest correct run.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_ITEMS  = 285;
    localparam int unsigned SETTLE_ticks = 8;

    typedef struct packed {
        rsd_in_t  item;
        bit       typed;
        rsd_out_t want;
    } script_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    rsd_in_t     s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rsd_out_t    m_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    // Shadow decoder state, updated once per accepted item.
    rsd_phase_t  phase;
    logic [14:0] count_left;
    logic [15:0] dest_ptr;
    logic [7:0]  word_lo;
    logic        ovr_flag;
    logic        done_flag;
    logic [15:0] fp_limit;

    rsd_out_t    pending_spans [$];
    rsd_out_t    span_want;
    script_row_t script [$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_mode     = RX_OPEN;
    int unsigned rx_left     = 0;
    int unsigned rx_hold     = 0;

    run_skip_dump_frame_decoder_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Move the destination by a skip, saturating at the clip limit.
    function automatic void clip_advance(input logic [15:0] len);
        logic [16:0] stop;
        stop = {1'b0, dest_ptr} + {1'b0, len};
        if (stop > {1'b0, fp_limit}) begin
            ovr_flag = 1'b1;
            stop     = {1'b0, fp_limit};
        end
        dest_ptr = stop[15:0];
    endfunction

    // Build one clipped span; spans of zero length or past the frame give nothing.
    function automatic bit clip_span(input logic [15:0] len, input logic [7:0] pix,
                                     output rsd_out_t span);
        logic [16:0] stop;
        logic [15:0] fill;
        span = NO_SPAN;
        if (len == 16'd0)
            return 1'b0;
        if (dest_ptr >= fp_limit) begin
            ovr_flag = 1'b1;
            dest_ptr = fp_limit;
            return 1'b0;
        end
        fill = len;
        stop = {1'b0, dest_ptr} + {1'b0, len};
        if (stop > {1'b0, fp_limit}) begin
            ovr_flag = 1'b1;
            fill     = fp_limit - dest_ptr;
        end
        span.dest_addr    = dest_ptr;
        span.span_length  = fill[13:0];
        span.pixel_value  = pix;
        span.end_of_frame = 1'b0;
        span.overrun      = ovr_flag;
        dest_ptr = dest_ptr + fill;
        return 1'b1;
    endfunction

    // Decode one stream byte; returns 1 when it yields a span or end item.
    function automatic bit decode_step(input rsd_in_t item, output rsd_out_t span);
        logic [7:0]  b;
        logic [15:0] word;
        logic [14:0] n;
        b    = item.code_byte;
        span = NO_SPAN;
        if (item.frame_start) begin
            phase      = PH_OPCODE;
            count_left = '0;
            dest_ptr   = '0;
            word_lo    = '0;
            ovr_flag   = 1'b0;
            done_flag  = 1'b0;
        end
        if (done_flag)
            return 1'b0;
        case (phase)
            PH_OPCODE: begin
                if (b == OPC_RUN) begin
                    phase = PH_RUN_COUNT;
                end else if (b < OPC_LONG) begin
                    count_left = {7'd0, b};
                    phase      = PH_DUMP;
                end else if (b != OPC_LONG) begin
                    clip_advance({9'd0, b[6:0]});
                end else begin
                    phase = PH_WORD_LO;
                end
                return 1'b0;
            end
            PH_DUMP: begin
                if (count_left != 15'd0)
                    count_left = count_left - 15'd1;
                if (count_left == 15'd0)
                    phase = PH_OPCODE;
                return clip_span(16'd1, b, span);
            end
            PH_RUN_COUNT: begin
                count_left = {7'd0, b};
                phase      = PH_RUN_PIXEL;
                return 1'b0;
            end
            PH_RUN_PIXEL: begin
                phase      = PH_OPCODE;
                n          = count_left;
                count_left = '0;
                return clip_span({1'b0, n}, b, span);
            end
            PH_WORD_LO: begin
                word_lo = b;
                phase   = PH_WORD_HI;
                return 1'b0;
            end
            PH_WORD_HI: begin
                word  = {b, word_lo};
                phase = PH_OPCODE;
                if (word == WORD_END) begin
                    done_flag         = 1'b1;
                    span.end_of_frame = 1'b1;
                    span.overrun      = ovr_flag;
                    return 1'b1;
                end
                if (!word[15]) begin
                    clip_advance(word);
                    return 1'b0;
                end
                // Bit 14 splits long run from long dump; a dump of zero does nothing.
                if (word[14]) begin
                    count_left = {1'b0, word[13:0]};
                    phase      = PH_RUN_PIXEL;
                end else if (word[13:0] != 14'd0) begin
                    count_left = {1'b0, word[13:0]};
                    phase      = PH_DUMP;
                end
                return 1'b0;
            end
            default: begin
                phase = PH_OPCODE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic script_row_t step_row(input logic [7:0] b, input logic fs);
        script_row_t r;
        r                  = '0;
        r.item.code_byte   = b;
        r.item.frame_start = fs;
        return r;
    endfunction

    function automatic script_row_t known_row(input logic [7:0] b, input logic [15:0] dest,
                                              input logic [13:0] len, input logic [7:0] pix,
                                              input logic eof, input logic ovr);
        script_row_t r;
        r                   = step_row(b, 1'b0);
        r.typed             = 1'b1;
        r.want.dest_addr    = dest;
        r.want.span_length  = len;
        r.want.pixel_value  = pix;
        r.want.end_of_frame = eof;
        r.want.overrun      = ovr;
        return r;
    endfunction

    // Offer one item, idling in bursts, then decode it once it is taken.
    task automatic send_item(input rsd_in_t item, input bit typed, input rsd_out_t want);
        int unsigned gap;
        rsd_out_t    span;
        bit          got;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left = burst_left - 1;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        got = decode_step(item, span);
        // Typed rows carry their own answer; the shadow decoder still advances.
        if (typed)
            pending_spans.push_back(want);
        else if (got)
            pending_spans.push_back(span);
    endtask

    // Drop valid, wait out every expected item, then let in-flight bytes clear.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge aclk);
        repeat (SETTLE_ticks) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    // Receiver: switch among always-ready, coin-flip and long-stall patterns.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_CHOKE);
            rx_left = $urandom_range(16, 160);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_hold != 0) begin
                    m_ready <= 1'b0;
                    rx_hold = rx_hold - 1;
                end else begin
                    m_ready <= 1'b1;
                    rx_hold = $urandom_range(0, 12);
                end
            end
        endcase
    end

    // Compare every accepted item against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_spans.size() == 0) begin
                $display("%0t: unexpected item dest=%0d len=%0d pix=%0d eof=%0b ovr=%0b",
                         $time, m_data.dest_addr, m_data.span_length, m_data.pixel_value,
                         m_data.end_of_frame, m_data.overrun);
                fail_count = fail_count + 1;
            end else begin
                span_want = pending_spans.pop_front();
                check_field("dest_addr", 32'(span_want.dest_addr),
                            32'(m_data.dest_addr));
                check_field("span_length", 32'(span_want.span_length),
                            32'(m_data.span_length));
                check_field("pixel_value", 32'(span_want.pixel_value),
                            32'(m_data.pixel_value));
                check_field("end_of_frame", 32'(span_want.end_of_frame),
                            32'(m_data.end_of_frame));
                check_field("overrun", 32'(span_want.overrun), 32'(m_data.overrun));
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL run_skip_dump_frame_decoder_core");
            $finish;
        end
    end

    initial begin
        logic [15:0] fp_plan [0:5];
        logic [7:0]  frame_bytes [$];
        logic [7:0]  b;
        logic [15:0] word;
        int unsigned target, ops, kind, n, keep, tail;
        rsd_in_t     item;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        // Shadow state matches the block straight out of reset.
        phase      = PH_OPCODE;
        count_left = '0;
        dest_ptr   = '0;
        word_lo    = '0;
        ovr_flag   = 1'b0;
        done_flag  = 1'b0;
        fp_limit   = FRAME_PIXELS_RESET;

        // Directed stream; no frame mark first, so decoding must start at pixel 0.
        script.push_back(step_row(8'h05, 1'b0));                        // dump of 5
        script.push_back(known_row(8'hFF, 16'd0, 14'd1, 8'hFF, 1'b0, 1'b0));
        script.push_back(known_row(8'h00, 16'd1, 14'd1, 8'h00, 1'b0, 1'b0));
        script.push_back(step_row(8'h3C, 1'b0));
        script.push_back(step_row(8'hC3, 1'b0));
        script.push_back(step_row(8'h7E, 1'b0));
        script.push_back(step_row(OPC_RUN, 1'b0));                      // short run
        script.push_back(step_row(8'hFF, 1'b0));                        // count 255
        script.push_back(known_row(8'hAB, 16'd5, 14'd255, 8'hAB, 1'b0, 1'b0));
        script.push_back(step_row(8'h81, 1'b0));                        // skip 1
        script.push_back(step_row(8'hFF, 1'b0));                        // skip 127
        script.push_back(step_row(OPC_RUN, 1'b0));                      // run of zero
        script.push_back(step_row(8'h00, 1'b0));
        script.push_back(step_row(8'h99, 1'b0));
        script.push_back(step_row(OPC_LONG, 1'b0));                     // longest run
        script.push_back(step_row(8'hFF, 1'b0));
        script.push_back(step_row(8'hFF, 1'b0));
        script.push_back(known_row(8'h5A, 16'd388, 14'd16383, 8'h5A, 1'b0, 1'b0));
        script.push_back(step_row(OPC_LONG, 1'b0));                     // long dump of zero
        script.push_back(step_row(8'h00, 1'b0));
        script.push_back(step_row(8'h80, 1'b0));
        script.push_back(step_row(OPC_LONG, 1'b0));                     // end marker
        script.push_back(step_row(WORD_END[7:0], 1'b0));
        script.push_back(known_row(WORD_END[15:8], 16'd0, 14'd0, 8'h00, 1'b1, 1'b0));
        script.push_back(step_row(8'h12, 1'b0));                        // ignored after end
        script.push_back(step_row(8'h81, 1'b1));                        // restart frame

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i])
            send_item(script[i].item, script[i].typed, script[i].want);

        // Clip limits: smallest, largest, tight, random small, reset value, any.
        fp_plan[0] = 16'd1;
        fp_plan[1] = 16'd65535;
        fp_plan[2] = 16'd200;
        fp_plan[3] = 16'($urandom_range(1, 2000));
        fp_plan[4] = FRAME_PIXELS_RESET;
        fp_plan[5] = 16'($urandom_range(1, 65535));

        for (int p = 0; p < 6; p++) begin
            drain_results();
            @(negedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= fp_plan[p];
            @(negedge aclk);
            cfg_wr_en <= 1'b0;
            fp_limit = fp_plan[p];

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: a loose byte, sometimes with a frame mark mid-stream.
                    item.code_byte   = 8'($urandom_range(0, 255));
                    item.frame_start = ($urandom_range(0, 3) == 0);
                    send_item(item, 1'b0, NO_SPAN);
                    items_sent = items_sent + 1;
                end else begin
                    // Well-formed frame of random opcodes, usually closed by the end word.
                    ops = $urandom_range(1, 10);
                    repeat (ops) begin
                        kind = $urandom_range(0, 99);
                        if (kind < 25) begin
                            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127)
                                                            : $urandom_range(1, 6);
                            b = 8'(n);
                            frame_bytes.push_back(b);
                            repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
                        end else if (kind < 45) begin
                            frame_bytes.push_back(OPC_RUN);
                            frame_bytes.push_back(8'($urandom_range(0, 255)));
                            frame_bytes.push_back(8'($urandom_range(0, 255)));
                        end else if (kind < 58) begin
                            b = 8'($urandom_range(1, 127));
                            frame_bytes.push_back(OPC_LONG | b);
                        end else begin
                            tail = 0;
                            if (kind < 70) begin
                                word = 16'($urandom_range(1, 16'h7FFF));
                            end else if (kind < 84) begin
                                n    = $urandom_range(0, 12);
                                word = LONG_DUMP_TAG | 16'(n);
                                tail = n;
                            end else begin
                                word = LONG_RUN_TAG | 16'($urandom_range(0, 16'h3FFF));
                                tail = 1;
                            end
                            frame_bytes.push_back(OPC_LONG);
                            frame_bytes.push_back(word[7:0]);
                            frame_bytes.push_back(word[15:8]);
                            repeat (tail) frame_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                    end
                    if ($urandom_range(0, 9) != 0) begin
                        frame_bytes.push_back(OPC_LONG);
                        frame_bytes.push_back(WORD_END[7:0]);
                        frame_bytes.push_back(WORD_END[15:8]);
                    end

                    // Now and then cut the frame short to break a sequence.
                    keep = frame_bytes.size();
                    if ($urandom_range(0, 19) == 0)
                        keep = $urandom_range(1, keep);
                    for (int i = 0; i < keep; i++) begin
                        item.code_byte   = frame_bytes[i];
                        item.frame_start = (i == 0);
                        send_item(item, 1'b0, NO_SPAN);
                    end
                    items_sent = items_sent + keep;

                    // Trailing bytes after the end word must be ignored.
                    if (keep == frame_bytes.size()) begin
                        repeat ($urandom_range(0, 2)) begin
                            item.code_byte   = 8'($urandom_range(0, 255));
                            item.frame_start = 1'b0;
                            send_item(item, 1'b0, NO_SPAN);
                        end
                    end
                    frame_bytes.delete();
                end
            end
        end

        drain_results();
        if (fail_count == 0)
            $display("PASS run_skip_dump_frame_decoder_core");
        else
            $display("FAIL run_skip_dump_frame_decoder_core");
        $finish;
    end

endmodule
